@@ design/isf_pkg.sv @@
// ----------------------------------------------------------------------------
// isf_pkg
// Shared types, widths and the acceptance table of the Metropolis flip engine.
// ----------------------------------------------------------------------------
package isf_pkg;

  localparam int MAX_SPINS_DEF     = 64;
  localparam int COUPLING_BITS_DEF = 16;

  localparam int REQ_W   = 2;
  localparam int SIDX_W  = 6;
  localparam int CVAL_W  = 16;
  localparam int DRAW_W  = 16;
  localparam int BETA_W  = 24;
  localparam int NSPIN_W = 7;
  localparam int DE_OUT_W = 24;
  localparam int ENERGY_W = 32;
  localparam int TIES_W   = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;

  localparam int ROM_LEN = 50;

  typedef enum logic [REQ_W-1:0] {
    REQ_COUPLING = 2'd0,
    REQ_SPIN     = 2'd1,
    REQ_ENERGY   = 2'd2,
    REQ_FLIP     = 2'd3
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BETA   = 1'b0,
    CFG_NSPINS = 1'b1
  } cfg_idx_t;

  // round(256*exp(-i/8)), Q1.8
  function automatic logic [8:0] exp_rom(input logic [5:0] i);
    logic [8:0] v;
    case (i)
      6'd0:  v = 9'd256;  6'd1:  v = 9'd226;  6'd2:  v = 9'd199;  6'd3:  v = 9'd176;
      6'd4:  v = 9'd155;  6'd5:  v = 9'd137;  6'd6:  v = 9'd121;  6'd7:  v = 9'd107;
      6'd8:  v = 9'd94;   6'd9:  v = 9'd83;   6'd10: v = 9'd73;   6'd11: v = 9'd65;
      6'd12: v = 9'd57;   6'd13: v = 9'd50;   6'd14: v = 9'd44;   6'd15: v = 9'd39;
      6'd16: v = 9'd35;   6'd17: v = 9'd31;   6'd18: v = 9'd27;   6'd19: v = 9'd24;
      6'd20: v = 9'd21;   6'd21: v = 9'd19;   6'd22: v = 9'd16;   6'd23: v = 9'd14;
      6'd24: v = 9'd13;   6'd25: v = 9'd11;   6'd26: v = 9'd10;   6'd27: v = 9'd9;
      6'd28: v = 9'd8;    6'd29: v = 9'd7;    6'd30: v = 9'd6;    6'd31: v = 9'd5;
      6'd32: v = 9'd5;    6'd33: v = 9'd4;    6'd34: v = 9'd4;    6'd35: v = 9'd3;
      6'd36: v = 9'd3;    6'd37: v = 9'd3;    6'd38: v = 9'd2;    6'd39: v = 9'd2;
      6'd40: v = 9'd2;    6'd41: v = 9'd2;    6'd42: v = 9'd1;    6'd43: v = 9'd1;
      6'd44: v = 9'd1;    6'd45: v = 9'd1;    6'd46: v = 9'd1;    6'd47: v = 9'd1;
      6'd48: v = 9'd1;    6'd49: v = 9'd1;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

endpackage

@@ design/isf_req_if.sv @@
// ----------------------------------------------------------------------------
// isf_req_if
// Request channel: valid/ready and one request beat.
// ----------------------------------------------------------------------------
interface isf_req_if;
  import isf_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [REQ_W-1:0]         req_type;
  logic [SIDX_W-1:0]        spin_index;
  logic [SIDX_W-1:0]        partner_index;
  logic signed [CVAL_W-1:0] coupling_value;
  logic                     spin_value;
  logic [DRAW_W-1:0]        uniform_draw;

  modport source (output valid, req_type, spin_index, partner_index, coupling_value,
                  spin_value, uniform_draw, input ready);
  modport sink   (input valid, req_type, spin_index, partner_index, coupling_value,
                  spin_value, uniform_draw, output ready);
endinterface

@@ design/isf_res_if.sv @@
// ----------------------------------------------------------------------------
// isf_res_if
// Result channel: valid/ready and one result beat.
// ----------------------------------------------------------------------------
interface isf_res_if;
  import isf_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       flip_accepted;
  logic signed [DE_OUT_W-1:0] energy_change;
  logic signed [ENERGY_W-1:0] total_energy;
  logic signed [ENERGY_W-1:0] lowest_energy;
  logic                       new_lowest;
  logic [TIES_W-1:0]          lowest_ties;

  modport source (output valid, flip_accepted, energy_change, total_energy,
                  lowest_energy, new_lowest, lowest_ties, input ready);
  modport sink   (input valid, flip_accepted, energy_change, total_energy,
                  lowest_energy, new_lowest, lowest_ties, output ready);
endinterface

@@ design/isf_spin_mem.sv @@
// ----------------------------------------------------------------------------
// isf_spin_mem
// Spin store: one write, two registered reads; per-entry valid bits make
// unwritten spins read as -1 (zero) after reset.
// ----------------------------------------------------------------------------
module isf_spin_mem #(
  parameter int DEPTH = 64,
  parameter int IW    = 6
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          we,
  input  logic [IW-1:0] waddr,
  input  logic          wdata,
  input  logic [IW-1:0] raddr_a,
  input  logic [IW-1:0] raddr_b,
  output logic          rdata_a,
  output logic          rdata_b
);
  logic mem [DEPTH];
  logic [DEPTH-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= vld[raddr_a] & mem[raddr_a];
    rdata_b <= vld[raddr_b] & mem[raddr_b];
  end
endmodule

@@ design/isf_coup_mem.sv @@
// ----------------------------------------------------------------------------
// isf_coup_mem
// Coupling store: single write port, single registered read port.
// ----------------------------------------------------------------------------
module isf_coup_mem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int DW    = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ design/ising_metropolis_flip.sv @@
// ----------------------------------------------------------------------------
// ising_metropolis_flip
// Metropolis spin-flip engine for an Ising spin glass.
//
// Requests arrive as beats on req; each gives exactly one beat on res.
// Config (beta, spin count N) is written on cfg_write/cfg_index/cfg_data
// while idle. One request is worked at a time; its steps from accept to result:
//   load coupling : two writes to the coupling memory (single write port)
//   load spin     : one spin write
//   recompute     : one coupling read per pair i<j, summed into the energy
//   attempt flip  : one coupling read per other spin of the row, then
//                   dE, beta*dE multiply, table lookup and update stages
//   (out-of-range flip: no reads, result directly)
// The result sits in an output register; a new request is taken while it
// waits, and the engine holds its next result until res is free.
// Reset (rst, synchronous) clears spins to -1, energy, minimum and tie count
// to 0, beta to 0 and N to 64. Couplings are undefined until loaded.
// ----------------------------------------------------------------------------
module ising_metropolis_flip #(
  parameter int MAX_SPINS     = isf_pkg::MAX_SPINS_DEF,
  parameter int COUPLING_BITS = isf_pkg::COUPLING_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [isf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [isf_pkg::CFG_DATA_W-1:0]  cfg_data,
  isf_req_if.sink                         req,
  isf_res_if.source                       res
);
  import isf_pkg::*;

  localparam int IW     = (MAX_SPINS > 1) ? $clog2(MAX_SPINS) : 1;
  localparam int NW     = $clog2(MAX_SPINS + 1);
  localparam int CDEPTH = MAX_SPINS * MAX_SPINS;
  localparam int CAW    = $clog2(CDEPTH);
  localparam int ACC_W  = COUPLING_BITS + 2 * NW + 1;
  localparam int DE_W   = ACC_W + 3;
  localparam int DX_W   = (DE_W > 34) ? DE_W : 35;
  localparam int PW     = BETA_W + 34;
  localparam int EW     = ((DE_W > ENERGY_W) ? DE_W : ENERGY_W) + 2;

  localparam logic signed [EW-1:0] E_MAX = EW'(64'sh7FFF_FFFF);
  localparam logic signed [EW-1:0] E_MIN = -EW'(64'sh8000_0000);
  localparam logic signed [DE_W-1:0] D_MAX = DE_W'(64'sh7F_FFFF);
  localparam logic signed [DE_W-1:0] D_MIN = -DE_W'(64'sh80_0000);

  typedef enum logic [3:0] {
    S_IDLE, S_CW1, S_CW2, S_SPW, S_ESWEEP, S_EDRAIN, S_ESET,
    S_FSWEEP, S_FDRAIN, S_FDE, S_FMUL, S_FDEC, S_FUPD, S_FIN
  } state_t;

  state_t state;

  logic [BETA_W-1:0]  beta;
  logic [NSPIN_W-1:0] nspins;
  logic [NW-1:0]      n_eff;

  logic [SIDX_W-1:0]        k_r, p_r;
  logic signed [CVAL_W-1:0] cv_r;
  logic                     sv_r;
  logic [DRAW_W-1:0]        draw_r;
  logic                     is_flip;
  logic [NW-1:0]            i, j;
  logic                     rd_vld;
  logic signed [ACC_W-1:0]  acc;
  logic signed [DE_W-1:0]   de_r;
  logic [PW-1:0]            prod_r;
  logic                     over_r;
  logic                     keep_r;
  logic signed [ENERGY_W-1:0] e_new;
  logic signed [ENERGY_W-1:0] energy, lowest;
  logic [TIES_W-1:0]        ties;
  logic                     r_acc, r_new;

  logic                     out_valid;
  logic                     o_acc, o_new;
  logic signed [DE_OUT_W-1:0] o_de;
  logic signed [ENERGY_W-1:0] o_energy, o_lowest;
  logic [TIES_W-1:0]        o_ties;

  logic            sp_we, sp_wdata, spin_a, spin_b;
  logic [IW-1:0]   sp_waddr, sp_ra, sp_rb;
  logic            cp_we;
  logic [CAW-1:0]  cp_waddr, cp_raddr;
  logic signed [COUPLING_BITS-1:0] cp_wdata, cp_rdata;

  logic [IW-1:0]   kidx, pidx, jidx, iidx;
  logic            issue, out_free;

  function automatic logic [CAW-1:0] caddr(input logic [IW-1:0] r, input logic [IW-1:0] c);
    return CAW'(32'(r) * MAX_SPINS + 32'(c));
  endfunction

  assign kidx = IW'(k_r);
  assign pidx = IW'(p_r);
  assign jidx = j[IW-1:0];
  assign iidx = i[IW-1:0];

  always_comb begin
    if (32'(nspins) > MAX_SPINS) begin
      n_eff = NW'(MAX_SPINS);
    end else begin
      n_eff = NW'(nspins);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beta   <= '0;
      nspins <= NSPIN_W'(64);
    end else if (cfg_write) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_BETA:   beta   <= cfg_data[BETA_W-1:0];
        CFG_NSPINS: nspins <= cfg_data[NSPIN_W-1:0];
        default: ;
      endcase
    end
  end

  // memory ports
  always_comb begin
    issue = ((state == S_ESWEEP) && (j < n_eff)) ||
            ((state == S_FSWEEP) && (j < n_eff) && (32'(j) != 32'(k_r)));
    sp_we    = ((state == S_SPW) && (32'(k_r) < MAX_SPINS)) ||
               ((state == S_FUPD) && keep_r);
    sp_waddr = kidx;
    sp_wdata = (state == S_SPW) ? sv_r : ~spin_a;
    sp_ra    = is_flip ? kidx : iidx;
    sp_rb    = jidx;
    cp_we    = ((state == S_CW1) || (state == S_CW2)) &&
               (32'(k_r) < MAX_SPINS) && (32'(p_r) < MAX_SPINS);
    cp_waddr = (state == S_CW1) ? caddr(kidx, pidx) : caddr(pidx, kidx);
    cp_wdata = COUPLING_BITS'(cv_r);
    if (!is_flip) begin
      cp_raddr = caddr(iidx, jidx);
    end else if (32'(j) < 32'(k_r)) begin
      cp_raddr = caddr(jidx, kidx);
    end else begin
      cp_raddr = caddr(kidx, jidx);
    end
  end

  isf_spin_mem #(.DEPTH(MAX_SPINS), .IW(IW)) u_spin (
    .clk(clk), .rst(rst), .we(sp_we), .waddr(sp_waddr), .wdata(sp_wdata),
    .raddr_a(sp_ra), .raddr_b(sp_rb), .rdata_a(spin_a), .rdata_b(spin_b)
  );

  isf_coup_mem #(.DEPTH(CDEPTH), .AW(CAW), .DW(COUPLING_BITS)) u_coup (
    .clk(clk), .we(cp_we), .waddr(cp_waddr), .wdata(cp_wdata),
    .raddr(cp_raddr), .rdata(cp_rdata)
  );

  // datapath terms
  logic signed [ACC_W-1:0] cext, term;
  logic                    neg_term;
  logic signed [DE_W-1:0]  acc4;
  logic signed [DX_W-1:0]  de_x;
  logic signed [ACC_W+1:0] e2;
  logic signed [EW-1:0]    e2x, esum;
  logic [PW-27-1:0]        idx;
  logic [16:0]             thr;
  logic                    keep;

  always_comb begin
    cext     = ACC_W'(cp_rdata);
    neg_term = is_flip ? ~spin_b : (spin_a ^ spin_b);
    term     = neg_term ? -cext : cext;
    acc4     = DE_W'(acc) <<< 2;
    de_x     = DX_W'(de_r);
    e2       = -((ACC_W + 2)'(acc) <<< 1);
    e2x      = EW'(e2);
    esum     = EW'(energy) + EW'(de_r);
    idx      = prod_r[PW-1:27];
    if (!over_r && (idx < (PW - 27)'(ROM_LEN))) begin
      thr = {exp_rom(idx[5:0]), 8'h00};
    end else begin
      thr = '0;
    end
    keep = de_r[DE_W-1] || ({1'b0, draw_r} < thr);
  end

  assign out_free = !out_valid || res.ready;
  assign req.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rd_vld    <= 1'b0;
      out_valid <= 1'b0;
      energy    <= '0;
      lowest    <= '0;
      ties      <= '0;
      is_flip   <= 1'b0;
      keep_r    <= 1'b0;
    end else begin
      rd_vld <= issue;
      if (rd_vld) begin
        acc <= acc + term;
      end
      if ((state == S_FIN) && out_free) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            k_r    <= req.spin_index;
            p_r    <= req.partner_index;
            cv_r   <= req.coupling_value;
            sv_r   <= req.spin_value;
            draw_r <= req.uniform_draw;
            r_acc  <= 1'b0;
            r_new  <= 1'b0;
            de_r   <= '0;
            keep_r <= 1'b0;
            acc    <= '0;
            is_flip <= (req_t'(req.req_type) == REQ_FLIP);
            unique case (req_t'(req.req_type))
              REQ_COUPLING: state <= S_CW1;
              REQ_SPIN:     state <= S_SPW;
              REQ_ENERGY: begin
                i     <= '0;
                j     <= NW'(1);
                state <= S_ESWEEP;
              end
              REQ_FLIP: begin
                j     <= '0;
                state <= (32'(req.spin_index) < 32'(n_eff)) ? S_FSWEEP : S_FIN;
              end
              default: state <= S_FIN;
            endcase
          end
        end
        S_CW1: state <= S_CW2;
        S_CW2: state <= S_FIN;
        S_SPW: state <= S_FIN;
        S_ESWEEP: begin
          if (j < n_eff) begin
            j <= j + NW'(1);
          end else if (32'(i) + 2 < 32'(n_eff)) begin
            i <= i + NW'(1);
            j <= i + NW'(2);
          end else begin
            state <= S_EDRAIN;
          end
        end
        S_EDRAIN: state <= S_ESET;
        S_ESET: begin
          if (e2x > E_MAX) begin
            energy <= ENERGY_W'(E_MAX);
            lowest <= ENERGY_W'(E_MAX);
          end else if (e2x < E_MIN) begin
            energy <= ENERGY_W'(E_MIN);
            lowest <= ENERGY_W'(E_MIN);
          end else begin
            energy <= ENERGY_W'(e2x);
            lowest <= ENERGY_W'(e2x);
          end
          ties  <= TIES_W'(1);
          state <= S_FIN;
        end
        S_FSWEEP: begin
          if (j < n_eff) begin
            j <= j + NW'(1);
          end else begin
            state <= S_FDRAIN;
          end
        end
        S_FDRAIN: state <= S_FDE;
        S_FDE: begin
          de_r  <= spin_a ? acc4 : -acc4;
          state <= S_FMUL;
        end
        S_FMUL: begin
          prod_r <= PW'(beta) * PW'(de_x[33:0]);
          over_r <= (|de_x[DX_W-1:34]) && (beta != '0);
          state  <= S_FDEC;
        end
        S_FDEC: begin
          keep_r <= keep;
          if (esum > E_MAX) begin
            e_new <= ENERGY_W'(E_MAX);
          end else if (esum < E_MIN) begin
            e_new <= ENERGY_W'(E_MIN);
          end else begin
            e_new <= ENERGY_W'(esum);
          end
          state <= S_FUPD;
        end
        S_FUPD: begin
          if (keep_r) begin
            r_acc  <= 1'b1;
            energy <= e_new;
            if (e_new < lowest) begin
              lowest <= e_new;
              ties   <= TIES_W'(1);
              r_new  <= 1'b1;
            end else if ((e_new == lowest) && (ties != '1)) begin
              ties <= ties + TIES_W'(1);
            end
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            o_acc     <= r_acc;
            o_new     <= r_new;
            o_energy  <= energy;
            o_lowest  <= lowest;
            o_ties    <= ties;
            if (de_r > D_MAX) begin
              o_de <= DE_OUT_W'(D_MAX);
            end else if (de_r < D_MIN) begin
              o_de <= DE_OUT_W'(D_MIN);
            end else begin
              o_de <= DE_OUT_W'(de_r);
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign res.valid         = out_valid;
  assign res.flip_accepted = o_acc;
  assign res.energy_change = o_de;
  assign res.total_energy  = o_energy;
  assign res.lowest_energy = o_lowest;
  assign res.new_lowest    = o_new;
  assign res.lowest_ties   = o_ties;
endmodule

@@ design/isf_checker.sv @@
// ----------------------------------------------------------------------------
// isf_checker
// Port-level checks for the flip engine, bound to the top level.
// ----------------------------------------------------------------------------
module isf_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic        flip_accepted,
  input logic        new_lowest,
  input logic [31:0] total_energy,
  input logic [31:0] lowest_energy
);
  a_rst_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result beat valid right after reset");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(total_energy))
    else $error("stalled result beat changed");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

  a_newlow_kept: assert property (@(posedge clk) disable iff (rst)
    res_valid && new_lowest |-> flip_accepted && (lowest_energy == total_energy))
    else $error("new minimum without a kept flip at that energy");
endmodule

bind ising_metropolis_flip isf_checker u_isf_checker (
  .clk(clk), .rst(rst),
  .req_valid(req.valid), .req_ready(req.ready),
  .res_valid(res.valid), .res_ready(res.ready),
  .flip_accepted(res.flip_accepted), .new_lowest(res.new_lowest),
  .total_energy(res.total_energy), .lowest_energy(res.lowest_energy)
);

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Metropolis spin-flip engine. A scoreboard class
// predicts each result beat from the accepted requests and checks the beats
// in order. Coupling loads are issued before any energy or flip request
// that would read them. The run covers several beta/N settings with random
// idling on both channels.
// ----------------------------------------------------------------------------
module tb;
  import isf_pkg::*;

  typedef struct {
    req_t                     kind;
    logic [SIDX_W-1:0]        k;
    logic [SIDX_W-1:0]        p;
    logic signed [CVAL_W-1:0] cv;
    logic                     sv;
    logic [DRAW_W-1:0]        draw;
  } spin_req_t;

  typedef struct {
    logic                       acc;
    logic signed [DE_OUT_W-1:0] de;
    logic signed [ENERGY_W-1:0] tot;
    logic signed [ENERGY_W-1:0] low;
    logic                       nl;
    logic [TIES_W-1:0]          ties;
  } flip_res_t;

  class ising_sb;
    bit          spin[64];
    longint      cpl[64][64];
    longint      energy, lowest;
    int unsigned ties, beta, nspins;
    int          exp_tab[50];
    int          errors;
    flip_res_t   pending_q[$];

    function new();
      exp_tab = '{256, 226, 199, 176, 155, 137, 121, 107, 94, 83,
                  73, 65, 57, 50, 44, 39, 35, 31, 27, 24,
                  21, 19, 16, 14, 13, 11, 10, 9, 8, 7,
                  6, 5, 5, 4, 4, 3, 3, 3, 2, 2,
                  2, 2, 1, 1, 1, 1, 1, 1, 1, 1};
      foreach (spin[i]) spin[i] = 0;
      foreach (cpl[i, j]) cpl[i][j] = 0;
      energy = 0; lowest = 0; ties = 0; beta = 0; nspins = 64; errors = 0;
    endfunction

    function longint sat(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function longint sgn(int i);
      return spin[i] ? 1 : -1;
    endfunction

    function void note(spin_req_t it);
      flip_res_t r;
      int n, k;
      longint h, de, acc, prod, idx, thr;
      bit keep;
      n = nspins > 64 ? 64 : nspins;
      k = int'(it.k);
      de = 0;
      keep = 0;
      r.acc = 0; r.nl = 0;
      case (it.kind)
        REQ_COUPLING: begin
          cpl[it.k][it.p] = it.cv;
          cpl[it.p][it.k] = it.cv;
        end
        REQ_SPIN: spin[k] = it.sv;
        REQ_ENERGY: begin
          acc = 0;
          for (int i = 0; i < n; i++) begin
            h = 0;
            for (int j = i + 1; j < n; j++) h += sgn(j) * cpl[i][j];
            acc += sgn(i) * h;
          end
          energy = sat(-2 * acc, -64'sd2147483648, 64'sd2147483647);
          lowest = energy;
          ties = 1;
        end
        REQ_FLIP: if (k < n) begin
          h = 0;
          for (int j = 0; j < n; j++)
            if (j != k) h += sgn(j) * cpl[k][j];
          de = 4 * sgn(k) * h;
          if (de < 0) keep = 1;
          else begin
            prod = longint'(beta) * de;
            idx = prod >>> 27;
            thr = idx < 50 ? exp_tab[idx] << 8 : 0;
            keep = longint'(it.draw) < thr;
          end
          if (keep) begin
            r.acc = 1;
            spin[k] = !spin[k];
            energy = sat(energy + de, -64'sd2147483648, 64'sd2147483647);
            if (energy < lowest) begin
              lowest = energy; ties = 1; r.nl = 1;
            end else if (energy == lowest && ties < 65535) ties++;
          end
        end
      endcase
      r.de = DE_OUT_W'(sat(de, -8388608, 8388607));
      r.tot = ENERGY_W'(energy);
      r.low = ENERGY_W'(lowest);
      r.ties = TIES_W'(ties);
      pending_q = {pending_q, r};
    endfunction

    function void mismatch(string f, longint e, longint a);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, f, e, a);
      errors++;
    endfunction

    function void check(flip_res_t a);
      flip_res_t e;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result beat", $time);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (a.acc !== e.acc) mismatch("flip_accepted", e.acc, a.acc);
      if (a.de !== e.de) mismatch("energy_change", e.de, a.de);
      if (a.tot !== e.tot) mismatch("total_energy", e.tot, a.tot);
      if (a.low !== e.low) mismatch("lowest_energy", e.low, a.low);
      if (a.nl !== e.nl) mismatch("new_lowest", e.nl, a.nl);
      if (a.ties !== e.ties) mismatch("lowest_ties", e.ties, a.ties);
    endfunction
  endclass

  localparam int LIMIT = 3000000;

  logic clk, rst;
  logic cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  isf_req_if req ();
  isf_res_if res ();

  ising_metropolis_flip u_dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .req(req.sink), .res(res.source)
  );

  ising_sb sb;
  bit      calm;
  int      stall_token, stall_seen, hold_left;
  int      cyc;
  bit      cpl_set[64][64];

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  always @(posedge clk) begin
    cyc++;
    if (cyc > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_token != stall_seen) begin
      stall_seen = stall_token;
      hold_left = 600;
    end
    if (hold_left > 0) begin
      hold_left--;
      res.ready <= 1'b0;
    end else begin
      res.ready <= calm || ($urandom_range(99) >= 26);
    end
  end

  always @(posedge clk) begin
    flip_res_t r;
    if (!rst && sb != null && res.valid && res.ready) begin
      r.acc = res.flip_accepted; r.de = res.energy_change; r.tot = res.total_energy;
      r.low = res.lowest_energy; r.nl = res.new_lowest; r.ties = res.lowest_ties;
      sb.check(r);
    end
  end

  task automatic send_req(input spin_req_t it);
    if (!calm && $urandom_range(99) < 26) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req.valid          <= 1'b1;
    req.req_type       <= it.kind;
    req.spin_index     <= it.k;
    req.partner_index  <= it.p;
    req.coupling_value <= it.cv;
    req.spin_value     <= it.sv;
    req.uniform_draw   <= it.draw;
    do @(posedge clk); while (!req.ready);
    sb.note(it);
    if (it.kind == REQ_COUPLING) begin
      cpl_set[it.k][it.p] = 1;
      cpl_set[it.p][it.k] = 1;
    end
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_cfg(input cfg_idx_t idx, input int unsigned val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_BETA) sb.beta = val;
    else sb.nspins = val & 8'h7f;
  endtask

  function automatic spin_req_t mk(req_t kind, int k, int p, int cv, bit sv, int draw);
    spin_req_t it;
    it.kind = kind; it.k = SIDX_W'(k); it.p = SIDX_W'(p); it.cv = CVAL_W'(cv);
    it.sv = sv; it.draw = DRAW_W'(draw);
    return it;
  endfunction

  function automatic logic signed [CVAL_W-1:0] rand_cpl();
    case ($urandom_range(9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      default: return CVAL_W'($urandom);
    endcase
  endfunction

  // turn a request that would read an unloaded coupling into a load of it
  function automatic spin_req_t legalize(spin_req_t it);
    int n;
    n = sb.nspins > 64 ? 64 : sb.nspins;
    if (it.kind == REQ_FLIP && it.k < n) begin
      for (int j = 0; j < n; j++)
        if (j != it.k && !cpl_set[it.k][j])
          return mk(REQ_COUPLING, it.k, j, rand_cpl(), 0, 0);
    end else if (it.kind == REQ_ENERGY) begin
      for (int i = 0; i < n; i++)
        for (int j = i + 1; j < n; j++)
          if (!cpl_set[i][j]) return mk(REQ_COUPLING, j, i, rand_cpl(), 0, 0);
    end
    return it;
  endfunction

  function automatic spin_req_t rand_req(int n);
    spin_req_t it;
    int w;
    w = $urandom_range(99);
    it.kind = w < 25 ? REQ_COUPLING : w < 40 ? REQ_SPIN : w < 45 ? REQ_ENERGY : REQ_FLIP;
    it.k = SIDX_W'((n > 0 && $urandom_range(9) < 8) ? $urandom_range(n - 1)
                                                    : $urandom_range(63));
    it.p = SIDX_W'((n > 0 && $urandom_range(9) < 8) ? $urandom_range(n - 1)
                                                    : $urandom_range(63));
    it.cv = rand_cpl();
    it.sv = 1'($urandom_range(1));
    case ($urandom_range(7))
      0: it.draw = 16'h0000;
      1: it.draw = 16'hffff;
      2: it.draw = DRAW_W'($urandom_range(511));
      default: it.draw = DRAW_W'($urandom);
    endcase
    return legalize(it);
  endfunction

  int unsigned phase_beta[9] = '{0, 24'h010000, 24'hffffff, 0, 0, 24'h000100,
                                 24'h002000, 24'h004000, 24'h000800};
  int unsigned phase_n[9]    = '{4, 8, 6, 1, 0, 16, 12, 127, 5};

  initial begin
    int n;
    rst = 1'b1;
    calm = 1'b0;
    cfg_write = 1'b0; cfg_index = '0; cfg_data = '0;
    req.valid = 1'b0; req.req_type = REQ_COUPLING; req.spin_index = '0;
    req.partner_index = '0; req.coupling_value = '0; req.spin_value = 1'b0;
    req.uniform_draw = '0;
    res.ready = 1'b0;
    stall_token = 0; stall_seen = 0; hold_left = 0; cyc = 0;
    foreach (cpl_set[i, j]) cpl_set[i][j] = 0;
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < 9; ph++) begin
      if (ph == 6) phase_beta[ph] = $urandom_range(24'hffffff);
      write_cfg(CFG_BETA, phase_beta[ph]);
      write_cfg(CFG_NSPINS, phase_n[ph]);
      n = phase_n[ph] > 64 ? 64 : phase_n[ph];
      calm = (ph == 2);
      if (ph == 0) begin
        send_req(mk(REQ_COUPLING, 0, 1, 16'sh7fff, 0, 0));
        send_req(mk(REQ_COUPLING, 2, 0, 16'sh8000, 0, 0));
        send_req(mk(REQ_COUPLING, 0, 3, 0, 0, 0));
        send_req(mk(REQ_COUPLING, 1, 2, 1, 0, 0));
        send_req(mk(REQ_COUPLING, 3, 1, -1, 0, 0));
        send_req(mk(REQ_COUPLING, 2, 3, 16'sh5555, 0, 0));
        send_req(mk(REQ_COUPLING, 63, 63, 16'shaaaa, 0, 0));
        send_req(mk(REQ_SPIN, 0, 0, 0, 1, 0));
        send_req(mk(REQ_SPIN, 3, 0, 0, 0, 0));
        send_req(mk(REQ_SPIN, 63, 0, 0, 1, 0));
        send_req(mk(REQ_ENERGY, 0, 0, 0, 0, 0));
        send_req(mk(REQ_FLIP, 0, 0, 0, 0, 16'hffff));
        send_req(mk(REQ_FLIP, 1, 0, 0, 0, 0));
        send_req(mk(REQ_FLIP, 63, 0, 0, 0, 0));
        send_req(mk(REQ_FLIP, 2, 0, 0, 1, 16'h8000));
        send_req(mk(REQ_FLIP, 2, 0, 0, 1, 0));
        send_req(mk(REQ_ENERGY, 0, 0, 0, 0, 0));
        send_req(mk(REQ_FLIP, 3, 0, 0, 0, 16'hffff));
      end
      for (int i = 0; i < 181; i++) begin
        if (ph == 1 && i == 60) stall_token++;
        if (ph == 5 && i == 100) drain();
        send_req(rand_req(n));
      end
      drain();
    end

    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

@@ sim.f @@
design/isf_pkg.sv
design/isf_req_if.sv
design/isf_res_if.sv
design/isf_spin_mem.sv
design/isf_coup_mem.sv
design/ising_metropolis_flip.sv
design/isf_checker.sv
verif/tb.sv
